>>> rtl/esd_pkg.sv
// Shared types, constants and helper functions for the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

  // Width of the internal emitted-byte counter; it saturates at its maximum.
  localparam int COUNT_WIDTH = 16;
  // Width of the reported length field.
  localparam int LEN_WIDTH   = 16;
  // Width wide enough to compare the counter against the length maximum.
  localparam int EXT_WIDTH   = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QLVL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [4:0] OCTAL_PREFIX   = 5'b00110;  // '0' to '7' share these upper bits

  // Input kind codes.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Decoder mode.
  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_OCT1 = 2'd2,
    MODE_OCT2 = 2'd3
  } esd_mode_t;

  // One or two result bytes produced by a single input beat.
  typedef struct packed {
    logic       two;   // a second byte follows the first
    logic [7:0] b0;
    logic [7:0] b1;
    logic       term;  // the last byte of this command is the terminator
  } esd_cmd_t;

  // Control byte for a simple escape letter, zero when the letter is not one.
  function automatic logic [7:0] control_of(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:          r = 8'd7;   // a
      8'h62:          r = 8'd8;   // b
      8'h66:          r = 8'd12;  // f
      8'h6E:          r = 8'd10;  // n
      8'h72:          r = 8'd13;  // r
      8'h74:          r = 8'd9;   // t
      8'h76:          r = 8'd11;  // v
      CHAR_BACKSLASH: r = 8'd92;
      default:        r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/esd_in_if.sv
// Input channel of the escape sequence decoder: source bytes and end markers.
`timescale 1ns / 1ps

interface esd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

>>> rtl/esd_out_if.sv
// Result channel of the escape sequence decoder: decoded bytes and terminator.
`timescale 1ns / 1ps

interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_terminator;
  logic [15:0] decoded_length;

  modport source (output valid, output out_byte, output is_terminator,
                  output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input is_terminator,
                  input decoded_length, output ready);
endinterface

>>> rtl/esd_front.sv
// Front part: accepts input beats, tracks escape mode and issues byte commands.
`timescale 1ns / 1ps

module esd_front (
  input  logic              clk,
  input  logic              rst_n,
  esd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push,
  output esd_pkg::esd_cmd_t cmd
);

  esd_pkg::esd_mode_t mode_r, mode_nxt;
  logic [7:0]         accum_r, accum_nxt;

  logic       accept;
  logic       is_octal;
  logic [2:0] digit;
  logic [7:0] ctrl;
  logic [7:0] shifted;
  logic       has_cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign is_octal    = (in_ch.in_byte[7:3] == esd_pkg::OCTAL_PREFIX);
  assign digit       = in_ch.in_byte[2:0];
  assign ctrl        = esd_pkg::control_of(in_ch.in_byte);
  assign shifted     = {accum_r[4:0], digit};

  // Next mode and octal accumulator.
  always_comb begin
    mode_nxt  = mode_r;
    accum_nxt = accum_r;
    if (in_ch.kind == esd_pkg::KIND_END) begin
      mode_nxt  = esd_pkg::MODE_TEXT;
      accum_nxt = 8'd0;
    end else begin
      case (mode_r)
        esd_pkg::MODE_TEXT: begin
          if (in_ch.in_byte == esd_pkg::CHAR_BACKSLASH) begin
            mode_nxt = esd_pkg::MODE_ESC;
          end
        end
        esd_pkg::MODE_ESC: begin
          if (ctrl != 8'd0) begin
            mode_nxt = esd_pkg::MODE_TEXT;
          end else if (is_octal) begin
            mode_nxt  = esd_pkg::MODE_OCT1;
            accum_nxt = {5'd0, digit};
          end else begin
            mode_nxt = esd_pkg::MODE_TEXT;
          end
        end
        esd_pkg::MODE_OCT1: begin
          if (is_octal) begin
            mode_nxt  = esd_pkg::MODE_OCT2;
            accum_nxt = shifted;
          end else begin
            accum_nxt = 8'd0;
            mode_nxt  = (in_ch.in_byte == esd_pkg::CHAR_BACKSLASH) ?
                        esd_pkg::MODE_ESC : esd_pkg::MODE_TEXT;
          end
        end
        esd_pkg::MODE_OCT2: begin
          accum_nxt = 8'd0;
          if (is_octal) begin
            mode_nxt = esd_pkg::MODE_TEXT;
          end else begin
            mode_nxt = (in_ch.in_byte == esd_pkg::CHAR_BACKSLASH) ?
                       esd_pkg::MODE_ESC : esd_pkg::MODE_TEXT;
          end
        end
        default: begin
          mode_nxt  = esd_pkg::MODE_TEXT;
          accum_nxt = 8'd0;
        end
      endcase
    end
  end

  // Command produced by the current beat.
  always_comb begin
    has_cmd = 1'b0;
    cmd     = '0;
    if (in_ch.kind == esd_pkg::KIND_END) begin
      // Flush any pending escape, then the terminator.
      has_cmd  = 1'b1;
      cmd.term = 1'b1;
      case (mode_r)
        esd_pkg::MODE_ESC: begin
          cmd.two = 1'b1;
        end
        esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
          cmd.two = 1'b1;
          cmd.b0  = accum_r;
        end
        default: begin
          cmd.two = 1'b0;
        end
      endcase
    end else begin
      case (mode_r)
        esd_pkg::MODE_TEXT: begin
          has_cmd = (in_ch.in_byte != esd_pkg::CHAR_BACKSLASH);
          cmd.b0  = in_ch.in_byte;
        end
        esd_pkg::MODE_ESC: begin
          if (ctrl != 8'd0) begin
            has_cmd = 1'b1;
            cmd.b0  = ctrl;
          end else if (!is_octal) begin
            // Unknown escape: a zero byte, then the byte itself as text.
            has_cmd = 1'b1;
            cmd.two = 1'b1;
            cmd.b1  = in_ch.in_byte;
          end
        end
        esd_pkg::MODE_OCT1: begin
          if (!is_octal) begin
            has_cmd = 1'b1;
            cmd.b0  = accum_r;
            cmd.two = (in_ch.in_byte != esd_pkg::CHAR_BACKSLASH);
            cmd.b1  = in_ch.in_byte;
          end
        end
        esd_pkg::MODE_OCT2: begin
          has_cmd = 1'b1;
          if (is_octal) begin
            cmd.b0 = shifted;
          end else begin
            cmd.b0  = accum_r;
            cmd.two = (in_ch.in_byte != esd_pkg::CHAR_BACKSLASH);
            cmd.b1  = in_ch.in_byte;
          end
        end
        default: begin
          has_cmd = 1'b0;
        end
      endcase
    end
  end

  assign push = accept && has_cmd;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= esd_pkg::MODE_TEXT;
      accum_r <= 8'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
    end
  end

endmodule

>>> rtl/esd_cmd_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module esd_cmd_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  esd_pkg::esd_cmd_t                  push_cmd,
  input  logic                               pop,
  output logic                               head_valid,
  output esd_pkg::esd_cmd_t                  head_cmd,
  output logic                               full,
  output logic [esd_pkg::QLVL_WIDTH-1:0]     level
);

  esd_pkg::esd_cmd_t                 mem_r [esd_pkg::QUEUE_DEPTH];
  logic [esd_pkg::QPTR_WIDTH-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [esd_pkg::QPTR_WIDTH-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [esd_pkg::QLVL_WIDTH-1:0]    level_r, level_nxt;
  logic                              do_pop;

  assign head_valid = (level_r != '0);
  assign full       = (level_r == esd_pkg::QLVL_WIDTH'(esd_pkg::QUEUE_DEPTH));
  assign level      = level_r;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and occupancy update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == esd_pkg::QPTR_WIDTH'(esd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == esd_pkg::QPTR_WIDTH'(esd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (!push && do_pop) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Storage; written only when there is room.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/esd_back.sv
// Back part: emits queued bytes one per beat and keeps the decoded length.
`timescale 1ns / 1ps

module esd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  esd_pkg::esd_cmd_t head_cmd,
  output logic              pop,
  esd_out_if.source         out_ch
);

  logic                            out_valid_r;
  logic [7:0]                      out_byte_r;
  logic                            out_term_r;
  logic [esd_pkg::LEN_WIDTH-1:0]   out_len_r;
  logic                            sel_r, sel_nxt;
  logic [esd_pkg::COUNT_WIDTH-1:0] count_r, count_nxt;

  logic                            load;
  logic                            last;
  logic [7:0]                      cur_byte;
  logic                            cur_term;
  logic [esd_pkg::COUNT_WIDTH-1:0] count_inc;
  logic [esd_pkg::EXT_WIDTH-1:0]   count_ext;
  logic [esd_pkg::LEN_WIDTH-1:0]   len_sat;

  // Pick the next byte of the head command when the output register is free.
  assign load     = head_valid && (!out_valid_r || out_ch.ready);
  assign last     = !head_cmd.two || sel_r;
  assign cur_byte = sel_r ? head_cmd.b1 : head_cmd.b0;
  assign cur_term = head_cmd.term && last;
  assign pop      = load && last;
  assign sel_nxt  = load ? !last : sel_r;

  // Saturating byte count and its saturated report width.
  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;
  assign count_ext = esd_pkg::EXT_WIDTH'(count_inc);
  assign len_sat   = (count_ext > esd_pkg::EXT_WIDTH'({esd_pkg::LEN_WIDTH{1'b1}})) ?
                     '1 : count_ext[esd_pkg::LEN_WIDTH-1:0];
  assign count_nxt = load ? (cur_term ? '0 : count_inc) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      count_r     <= '0;
    end else begin
      sel_r   <= sel_nxt;
      count_r <= count_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_term_r <= cur_term;
      out_len_r  <= cur_term ? len_sat : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.is_terminator  = out_term_r;
  assign out_ch.decoded_length = out_len_r;

endmodule

>>> rtl/escape_sequence_decoder.sv
// Top level of the C-style escape sequence decoder.
//
// Input channel in_ch carries one beat per source byte (kind data) or an end
// marker (kind end). Result channel out_ch carries decoded bytes; the last
// beat of a string is a zero byte with is_terminator set and decoded_length
// giving the number of bytes emitted for the string, terminator included.
// The front part tracks the escape mode and turns each input beat into a
// command of zero, one or two bytes; a two-entry queue holds commands and the
// back part emits them one per cycle while out_ch.ready is high, through a
// registered output stage; an accepted beat goes into the queue and then into
// the output register. Throughput is one input beat per cycle while each beat
// yields at most one byte and out_ch.ready is high; a beat that yields two
// bytes ties up the single output port, so the queue fills and input is held.
// When out_ch.ready is low the output register holds its beat, the queue
// fills and in_ch.ready drops; no result is lost. Synchronous active-low
// reset returns the decoder to plain text, clears the byte count and
// empties the queue.
`timescale 1ns / 1ps

module escape_sequence_decoder (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);

  logic                           push;
  esd_pkg::esd_cmd_t              push_cmd;
  logic                           q_full;
  logic                           head_valid;
  esd_pkg::esd_cmd_t              head_cmd;
  logic                           pop;
  logic [esd_pkg::QLVL_WIDTH-1:0] q_level;

  esd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  esd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .full       (q_full),
    .level      (q_level)
  );

  esd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  // The terminator is a zero byte and always counts at least itself.
  a_term_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_terminator) |->
      (out_ch.out_byte == 8'd0 && out_ch.decoded_length != 16'd0))
    else $error("terminator beat with bad byte or length");

  // Ordinary bytes report no length.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.is_terminator) |-> (out_ch.decoded_length == 16'd0))
    else $error("length reported on a non-terminator beat");

  // The queue never holds more than its depth.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= esd_pkg::QLVL_WIDTH'(esd_pkg::QUEUE_DEPTH))
    else $error("command queue overflow");

  // Input is refused exactly when the queue is full.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_full)
    else $error("input ready disagrees with queue state");
`endif

endmodule

>>> dv/tb.sv
// Self-checking testbench for the escape sequence decoder.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 345;
  localparam int HOLD_CYCLES   = 200;
  localparam longint unsigned COUNT_MAX = (64'd1 << esd_pkg::COUNT_WIDTH) - 64'd1;
  localparam longint unsigned LEN_MAX   = (64'd1 << esd_pkg::LEN_WIDTH) - 64'd1;

  // One decoded beat as it should appear on the result channel.
  typedef struct packed {
    logic [7:0]                    ch;
    logic                          term;
    logic [esd_pkg::LEN_WIDTH-1:0] len;
  } dec_result_t;

  logic clk;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Decoder state mirrored by the testbench.
  esd_pkg::esd_mode_t dec_mode     = esd_pkg::MODE_TEXT;
  logic [7:0]         octal_value  = 8'd0;
  longint unsigned    emitted_cnt  = 0;
  dec_result_t        decoded_q[$];

  int err_count      = 0;
  int items_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sink_hold_len  = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Control byte for a simple escape letter, zero when there is none.
  function automatic logic [7:0] simple_escape_code(input logic [7:0] c);
    case (c)
      "a":                     return 8'd7;
      "b":                     return 8'd8;
      "f":                     return 8'd12;
      "n":                     return 8'd10;
      "r":                     return 8'd13;
      "t":                     return 8'd9;
      "v":                     return 8'd11;
      esd_pkg::CHAR_BACKSLASH: return 8'd92;
      default:                 return 8'd0;
    endcase
  endfunction

  // Queue one decoded byte, advancing the saturating length count.
  function automatic void emit_decoded(input logic [7:0] b, input logic term);
    dec_result_t r;
    if (emitted_cnt < COUNT_MAX) emitted_cnt++;
    r.ch   = b;
    r.term = term;
    r.len  = term ? esd_pkg::LEN_WIDTH'((emitted_cnt > LEN_MAX) ? LEN_MAX : emitted_cnt)
                  : '0;
    decoded_q.push_back(r);
  endfunction

  // Plain text handling: a backslash opens an escape, anything else passes.
  function automatic void take_text_byte(input logic [7:0] c);
    if (c == esd_pkg::CHAR_BACKSLASH) dec_mode = esd_pkg::MODE_ESC;
    else emit_decoded(c, 1'b0);
  endfunction

  // Work out the decoded bytes that one accepted input beat causes.
  function automatic void decode_beat(input logic kind, input logic [7:0] c);
    logic is_octal;
    is_octal = (c >= "0") && (c <= "7");
    if (kind == esd_pkg::KIND_END) begin
      // Flush a pending escape, then the terminator, then start afresh.
      case (dec_mode)
        esd_pkg::MODE_ESC:                     emit_decoded(8'd0, 1'b0);
        esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: emit_decoded(octal_value, 1'b0);
        default: ;
      endcase
      emit_decoded(8'd0, 1'b1);
      dec_mode    = esd_pkg::MODE_TEXT;
      octal_value = 8'd0;
      emitted_cnt = 0;
      return;
    end
    case (dec_mode)
      esd_pkg::MODE_TEXT: take_text_byte(c);
      esd_pkg::MODE_ESC: begin
        if (simple_escape_code(c) != 8'd0) begin
          emit_decoded(simple_escape_code(c), 1'b0);
          dec_mode = esd_pkg::MODE_TEXT;
        end else if (is_octal) begin
          octal_value = {5'd0, c[2:0]};
          dec_mode    = esd_pkg::MODE_OCT1;
        end else begin
          emit_decoded(8'd0, 1'b0);
          dec_mode = esd_pkg::MODE_TEXT;
          take_text_byte(c);
        end
      end
      default: begin
        if (is_octal) begin
          octal_value = {octal_value[4:0], c[2:0]};
          if (dec_mode == esd_pkg::MODE_OCT1) begin
            dec_mode = esd_pkg::MODE_OCT2;
          end else begin
            // The third digit closes the escape at once.
            emit_decoded(octal_value, 1'b0);
            octal_value = 8'd0;
            dec_mode    = esd_pkg::MODE_TEXT;
          end
        end else begin
          emit_decoded(octal_value, 1'b0);
          octal_value = 8'd0;
          dec_mode    = esd_pkg::MODE_TEXT;
          take_text_byte(c);
        end
      end
    endcase
  endfunction

  // Offer one beat after a random gap and wait for the handshake.
  task automatic send_beat(input logic kind, input logic [7:0] b);
    int  gap;
    logic taken;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.in_byte <= b;
    // Sample the handshake at the falling edge ahead of the rising edge that takes it.
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      if (taken) decode_beat(kind, b);
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic end_string();
    send_beat(esd_pkg::KIND_END, 8'($urandom));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(esd_pkg::KIND_DATA, s[i]);
  endtask

  // Stop offering beats until every expected result has come out.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_octal_digit();
    return 8'("0" + $urandom_range(7));
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(7))
      0:       return "a";
      1:       return "b";
      2:       return "f";
      3:       return "n";
      4:       return "r";
      5:       return "t";
      6:       return "v";
      default: return esd_pkg::CHAR_BACKSLASH;
    endcase
  endfunction

  // A random string mixing plain bytes, well-formed escapes and malformed ones.
  task automatic send_random_string(input int max_tokens);
    int n_tokens;
    n_tokens = $urandom_range(max_tokens);
    for (int t = 0; t < n_tokens; t++) begin
      case ($urandom_range(9))
        0, 1, 2: send_beat(esd_pkg::KIND_DATA, 8'($urandom));
        3, 4: begin
          send_beat(esd_pkg::KIND_DATA, esd_pkg::CHAR_BACKSLASH);
          send_beat(esd_pkg::KIND_DATA, pick_escape_letter());
        end
        5, 6: begin
          send_beat(esd_pkg::KIND_DATA, esd_pkg::CHAR_BACKSLASH);
          repeat ($urandom_range(3, 1)) send_beat(esd_pkg::KIND_DATA, random_octal_digit());
        end
        7: begin
          send_beat(esd_pkg::KIND_DATA, esd_pkg::CHAR_BACKSLASH);
          send_beat(esd_pkg::KIND_DATA, 8'($urandom));
        end
        8:       send_beat(esd_pkg::KIND_DATA, esd_pkg::CHAR_BACKSLASH);
        default: send_beat(esd_pkg::KIND_DATA, random_octal_digit());
      endcase
    end
    end_string();
  endtask

  // Every simple escape letter, backslash included.
  task automatic test_simple_escapes();
    send_text("\\a\\b\\f\\n\\r\\t\\v\\\\");
    end_string();
    wait_drain();
  endtask

  // Octal escapes: a third digit that wraps past 255, a non-octal byte after
  // one and after two digits, an unknown escape, a trailing backslash and
  // digits still pending at the end of the string.
  task automatic test_octal_escapes();
    send_text("\\777\\3z\\8");
    end_string();
    send_text("\\12\\");
    end_string();
    send_text("\\5");
    end_string();
    wait_drain();
  endtask

  // Extreme byte values and an empty string.
  task automatic test_edge_strings();
    send_beat(esd_pkg::KIND_DATA, 8'h00);
    send_beat(esd_pkg::KIND_DATA, 8'hFF);
    end_string();
    end_string();
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_backpressure();
    sink_hold_len = HOLD_CYCLES;
    send_text("\\8\\8\\12q");
    for (int k = 0; k < 24; k++) send_beat(esd_pkg::KIND_DATA, 8'($urandom));
    end_string();
    wait_drain();
  endtask

  // Random strings under one idling setting.
  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
    int target;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    target         = items_sent + n_items;
    while (items_sent < target) send_random_string(12);
    wait_drain();
  endtask

  // Result ready, with random stalls and the occasional long hold.
  initial begin : sink_ready_driver
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        hold          = sink_hold_len;
        sink_hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  initial begin : result_checker
    dec_result_t got;
    dec_result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.ch   = out_ch.out_byte;
        got.term = out_ch.is_terminator;
        got.len  = out_ch.decoded_length;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected beat: byte %h term %b len %0d",
                   $time, got.ch, got.term, got.len);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected byte %h term %b len %0d, got byte %h term %b len %0d",
                     $time, want.ch, want.term, want.len, got.ch, got.term, got.len);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : run_watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= esd_pkg::KIND_DATA;
    in_ch.in_byte <= 8'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_simple_escapes();
    test_octal_escapes();
    test_edge_strings();
    test_output_backpressure();
    test_random_traffic(0, 0, RANDOM_ITEMS);
    test_random_traffic(59, 0, RANDOM_ITEMS);
    test_random_traffic(0, 59, RANDOM_ITEMS);
    test_random_traffic(33, 33, RANDOM_ITEMS);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
